>>> hdl/arar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address range attribute map package
// Shared types, field widths, command and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package arar_pkg;

    // Fixed field widths of the transaction payloads
    localparam int IN_ADDR_W    = 32;
    localparam int IN_MARKER_W  = 8;
    localparam int OUT_MARKER_W = 8;
    localparam int OUT_IDX_W    = 6;

    // Parameter defaults
    localparam int DEF_MAX_AREAS   = 64;
    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_MARKER_BITS = 8;

    // Command codes
    localparam logic CMD_DEFINE = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [IN_ADDR_W-1:0]   address;
        logic [IN_MARKER_W-1:0] new_marker;
    } t_in_item;

    typedef struct packed {
        logic [OUT_MARKER_W-1:0] marker;
        logic [OUT_IDX_W-1:0]    area_index;
        logic                    status;
    } t_out_item;

endpackage
`default_nettype wire

>>> hdl/arar_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module arar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/address_range_attribute_map_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address range attribute map unit
// Sorted table of contiguous address areas with a marker each. Find returns
// the marker of the area holding an address; define overwrites or splits.
// ----------------------------------------------------------------------------
//
//  Channel  | Valid        | Stall        | Payload
//  ---------+--------------+--------------+---------------------------------
//  request  | i_in_valid   | o_in_stall   | i_in_item  (command, address,
//           |              |              |             new_marker)
//  result   | o_out_valid  | i_out_stall  | o_out_item (marker, area_index,
//           |              |              |             status)
//
//  Each transaction: accept in idle, a read and a compare per search step
//  (about log2 of the area count), a final read and check, a result load;
//  a split adds a read and a write per area shifted up and an insert write.
//  The table RAM reads one entry and writes one per cycle.
//  Reset leaves one area over the whole address space, marker 0, with no
//  clearing pass. A stalled result holds only the step that loads the next.
//
module address_range_attribute_map_unit #(
    parameter int MAX_AREAS   = arar_pkg::DEF_MAX_AREAS,
    parameter int ADDR_BITS   = arar_pkg::DEF_ADDR_BITS,
    parameter int MARKER_BITS = arar_pkg::DEF_MARKER_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire arar_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output arar_pkg::t_out_item      o_out_item
);

    localparam int IDX_W = $clog2(MAX_AREAS);
    localparam int CNT_W = $clog2(MAX_AREAS + 1);
    localparam int ENT_W = ADDR_BITS + MARKER_BITS;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_FIN_RD   = 9'b000001000,
        S_FIN_CHK  = 9'b000010000,
        S_SH_RD    = 9'b000100000,
        S_SH_WR    = 9'b001000000,
        S_INS      = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Request held for the whole transaction
    logic                   r_cmd;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [MARKER_BITS-1:0] r_mk;

    // Search bounds, shift pointer, table fill
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_count, n_count;

    // Entry 0 marker has been written since reset
    logic r_e0_valid, n_e0_valid;
    // Last RAM read addressed entry 0
    logic r_rd_is0;

    // Pending result and output register
    logic [MARKER_BITS-1:0] r_res_mk, n_res_mk;
    logic [IDX_W-1:0]       r_res_idx, n_res_idx;
    logic                   r_res_st, n_res_st;
    logic                   r_out_valid, n_out_valid;
    arar_pkg::t_out_item    r_out, n_out;

    // RAM port
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic [ENT_W-1:0] w_rd_data;

    // Decoded entry read back
    logic [ADDR_BITS-1:0]   w_rd_start;
    logic [MARKER_BITS-1:0] w_rd_mk;

    // Input fields brought to the table widths
    logic [ADDR_BITS+arar_pkg::IN_ADDR_W-1:0]     w_addr_ext;
    logic [MARKER_BITS+arar_pkg::IN_MARKER_W-1:0] w_mk_ext;
    // Result fields brought to the payload widths
    logic [MARKER_BITS+arar_pkg::OUT_MARKER_W-1:0] w_res_mk_ext;
    logic [IDX_W+arar_pkg::OUT_IDX_W-1:0]          w_res_idx_ext;

    // Search midpoint and split bookkeeping
    logic [IDX_W:0]   w_span;
    logic [IDX_W-1:0] w_mid;
    logic [CNT_W-1:0] w_sel1;
    logic [CNT_W-1:0] w_i_dec;

    logic w_out_free;

    assign w_addr_ext = {{ADDR_BITS{1'b0}}, i_in_item.address};
    assign w_mk_ext   = {{MARKER_BITS{1'b0}}, i_in_item.new_marker};

    assign w_res_mk_ext  = {{arar_pkg::OUT_MARKER_W{1'b0}}, r_res_mk};
    assign w_res_idx_ext = {{arar_pkg::OUT_IDX_W{1'b0}}, r_res_idx};

    // Entry 0 always starts at zero; its marker is zero until first written
    assign w_rd_start = r_rd_is0 ? '0 : w_rd_data[ENT_W-1:MARKER_BITS];
    assign w_rd_mk    = (r_rd_is0 && !r_e0_valid) ? '0 : w_rd_data[MARKER_BITS-1:0];

    // mid = lo + (hi - lo + 1) / 2, always above lo
    assign w_span = {1'b0, r_hi} - {1'b0, r_lo} + {{IDX_W{1'b0}}, 1'b1};
    assign w_mid  = r_lo + w_span[IDX_W:1];

    assign w_sel1  = CNT_W'(r_lo) + CNT_W'(1);
    assign w_i_dec = r_i - CNT_W'(1);

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    arar_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_AREAS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_i         = r_i;
        n_count     = r_count;
        n_e0_valid  = r_e0_valid;
        n_res_mk    = r_res_mk;
        n_res_idx   = r_res_idx;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_lo;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_lo;
        w_wr_data   = {r_addr, r_mk};

        // Drop the result once it has been taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lo = '0;
                    n_hi = IDX_W'(r_count - CNT_W'(1));
                    if (r_count > CNT_W'(1)) begin
                        n_state = S_SRCH_RD;
                    end else begin
                        n_state = S_FIN_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                // Fetch the start of the midpoint area
                n_mid     = w_mid;
                w_rd_en   = 1'b1;
                w_rd_addr = w_mid;
                n_state   = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                // Keep the last area whose start is at or below the address
                if (w_rd_start <= r_addr) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid - IDX_W'(1);
                end
                if (n_lo < n_hi) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_FIN_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_lo;
                n_state   = S_FIN_CHK;
            end
            S_FIN_CHK: begin
                n_res_idx = r_lo;
                n_res_st  = arar_pkg::STATUS_DONE;
                n_res_mk  = w_rd_mk;
                if (r_cmd == arar_pkg::CMD_FIND) begin
                    n_state = S_DONE;
                end else if (w_rd_start == r_addr) begin
                    // Area starts at the address: overwrite its marker
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_lo;
                    w_wr_data = {r_addr, r_mk};
                    n_res_mk  = r_mk;
                    if (r_lo == '0) begin
                        n_e0_valid = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (r_count >= CNT_W'(MAX_AREAS)) begin
                    // No room to split: report the holding area as it is
                    n_res_st = arar_pkg::STATUS_FULL;
                    n_state  = S_DONE;
                end else if (r_count > w_sel1) begin
                    n_i     = r_count;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_SH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = IDX_W'(w_i_dec);
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                // Move entry i-1 up to i; entries here are never entry 0
                w_wr_en   = 1'b1;
                w_wr_addr = IDX_W'(r_i);
                w_wr_data = w_rd_data;
                n_i       = w_i_dec;
                if (w_i_dec > w_sel1) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                // New area from the address to the old end of the split area
                w_wr_en   = 1'b1;
                w_wr_addr = IDX_W'(w_sel1);
                w_wr_data = {r_addr, r_mk};
                n_count   = r_count + CNT_W'(1);
                n_res_mk  = r_mk;
                n_res_idx = IDX_W'(w_sel1);
                n_res_st  = arar_pkg::STATUS_DONE;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    n_out.marker     = w_res_mk_ext[arar_pkg::OUT_MARKER_W-1:0];
                    n_out.area_index = w_res_idx_ext[arar_pkg::OUT_IDX_W-1:0];
                    n_out.status     = r_res_st;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_e0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_is0    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_e0_valid  <= n_e0_valid;
            r_out_valid <= n_out_valid;
            if (w_rd_en) begin
                r_rd_is0 <= (w_rd_addr == '0);
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_in_item.command;
            r_addr <= w_addr_ext[ADDR_BITS-1:0];
            r_mk   <= w_mk_ext[MARKER_BITS-1:0];
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_i       <= n_i;
        r_res_mk  <= n_res_mk;
        r_res_idx <= n_res_idx;
        r_res_st  <= n_res_st;
        r_out     <= n_out;
    end

endmodule
`default_nettype wire
